### hw/rtl/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue
// used by spq_cell and sorted_priority_queue; depends on nothing
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;

    // operation codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND  = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] pri;
    } t_entry;

    typedef enum logic [1:0] {
        C_HOLD,
        C_PUSH,
        C_POP,
        C_REMOVE
    } t_cell_cmd;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_cmd cmd;
        t_entry    key;
    } t_cell_ctl;

    // handed from one cell to its neighbor
    typedef struct packed {
        t_entry ent;
        logic   stay;
        logic   hit;
    } t_link;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_INSERT
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/spq_cell.sv
// spq_cell: one slot of the sorted queue, holds one entry
// talks to its two neighbors; uses spq_pkg
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_valid,
    input  wire t_cell_ctl i_ctl,
    input  wire t_link     i_prev,
    input  wire t_entry    i_next,
    output t_link          o_link
);

    t_entry r_ent;
    t_entry n_ent;
    logic   stay;
    logic   hit;

    // entries at or above the key priority keep their slot on a push
    assign stay = i_valid && (r_ent.pri >= i_ctl.key.pri);
    // prefix of value matches, first match and everything after it moves up
    assign hit  = i_prev.hit || (i_valid && (r_ent.val == i_ctl.key.val));

    always_comb begin
        n_ent = r_ent;
        unique case (i_ctl.cmd)
            C_HOLD: begin
                n_ent = r_ent;
            end
            C_PUSH: begin
                if (stay) begin
                    n_ent = r_ent;
                end else if (i_prev.stay) begin
                    n_ent = i_ctl.key;
                end else begin
                    n_ent = i_prev.ent;
                end
            end
            C_POP: begin
                n_ent = i_next;
            end
            C_REMOVE: begin
                n_ent = hit ? i_next : r_ent;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_link.ent  = r_ent;
    assign o_link.stay = stay;
    assign o_link.hit  = hit;

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue.sv
// sorted_priority_queue: top level, controller plus a row of spq_cell slots
// uses spq_pkg and spq_cell
`default_nettype none

// Bounded priority queue of QUEUE_DEPTH entries, sorted by descending
// priority, first-in first-out among equal priorities.
// Command channel: a word (i_opcode, i_item_value, i_item_priority) is taken
// at a rising edge where start is high and busy is low.
// Result channel: one result word per command, shown for exactly one cycle
// while o_done is high; the receiver cannot stall it.
// Push, pop and unused opcodes: the result appears in the cycle after the
// command is taken, and busy stays low, so a command can be taken every cycle.
// Update with k matching entries: the row removes one match per cycle, then
// re-inserts one copy per cycle; the result comes in the cycle after the last
// re-insert, or after the command when nothing matches; busy is high meanwhile.
// The cells all shift their contents to a neighbor in the same cycle, which sets
// the one-operation-per-cycle pace of the row.
// Reset (i_rst_n low, synchronous) empties the queue and returns to idle;
// entry storage is not cleared.
module sorted_priority_queue import spq_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_opcode,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    input  wire logic signed [DATA_W-1:0] i_item_priority,
    output logic                          o_done,
    output logic signed [DATA_W-1:0]      o_out_value,
    output logic signed [DATA_W-1:0]      o_out_priority,
    output logic [1:0]                    o_status,
    output logic [OCC_W-1:0]              o_occupancy
);

    t_state                   r_state, n_state;
    logic [OCC_W-1:0]         r_count, n_count;
    logic [OCC_W-1:0]         r_left, n_left;
    logic signed [DATA_W-1:0] r_key_val, n_key_val;
    logic signed [DATA_W-1:0] r_key_pri, n_key_pri;
    logic                     r_done, n_done;
    logic signed [DATA_W-1:0] r_out_val, n_out_val;
    logic signed [DATA_W-1:0] r_out_pri, n_out_pri;
    logic [1:0]               r_status, n_status;

    logic      accept;
    logic      any_hit;
    t_cell_ctl ctl;
    t_link     links [QUEUE_DEPTH];

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        t_link  prev;
        t_entry next;
        logic   valid;

        assign valid = (r_count > OCC_W'(i));

        if (i == 0) begin : g_head
            assign prev.ent  = '0;
            assign prev.stay = 1'b1;
            assign prev.hit  = 1'b0;
        end else begin : g_body
            assign prev = links[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign next = links[i].ent;
        end else begin : g_mid
            assign next = links[i+1].ent;
        end

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_valid (valid),
            .i_ctl   (ctl),
            .i_prev  (prev),
            .i_next  (next),
            .o_link  (links[i])
        );
    end

    assign any_hit = links[QUEUE_DEPTH-1].hit;

    always_comb begin
        // key comes straight from the ports while idle so a command acts at once
        if (r_state == S_IDLE) begin
            ctl.key.val = i_item_value;
            ctl.key.pri = i_item_priority;
        end else begin
            ctl.key.val = r_key_val;
            ctl.key.pri = r_key_pri;
        end
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_key_val = r_key_val;
        n_key_pri = r_key_pri;
        n_done    = 1'b0;
        n_out_val = '0;
        n_out_pri = '0;
        n_status  = ST_OK;
        ctl.cmd   = C_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key_val = i_item_value;
                    n_key_pri = i_item_priority;
                    unique case (i_opcode)
                        OP_PUSH: begin
                            n_done = 1'b1;
                            if (r_count == OCC_W'(QUEUE_DEPTH)) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                ctl.cmd = C_PUSH;
                                n_count = r_count + OCC_W'(1);
                            end
                        end
                        OP_POP: begin
                            n_done = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                ctl.cmd   = C_POP;
                                n_out_val = links[0].ent.val;
                                n_out_pri = links[0].ent.pri;
                                n_count   = r_count - OCC_W'(1);
                            end
                        end
                        OP_UPDATE: begin
                            if (any_hit) begin
                                ctl.cmd = C_REMOVE;
                                n_count = r_count - OCC_W'(1);
                                n_left  = OCC_W'(1);
                                n_state = S_REMOVE;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_NOTFOUND;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_REMOVE: begin
                if (any_hit) begin
                    ctl.cmd = C_REMOVE;
                    n_count = r_count - OCC_W'(1);
                    n_left  = r_left + OCC_W'(1);
                end else begin
                    // no match left, first re-insert goes now
                    ctl.cmd = C_PUSH;
                    n_count = r_count + OCC_W'(1);
                    n_left  = r_left - OCC_W'(1);
                    if (r_left == OCC_W'(1)) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_INSERT: begin
                ctl.cmd = C_PUSH;
                n_count = r_count + OCC_W'(1);
                n_left  = r_left - OCC_W'(1);
                if (r_left == OCC_W'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_val <= n_key_val;
        r_key_pri <= n_key_pri;
        r_out_val <= n_out_val;
        r_out_pri <= n_out_pri;
        r_status  <= n_status;
    end

    assign o_done         = r_done;
    assign o_out_value    = r_out_val;
    assign o_out_priority = r_out_pri;
    assign o_status       = r_status;
    assign o_occupancy    = r_count;

    // held entries are in descending priority order
    logic [QUEUE_DEPTH-2:0] pair_ok;
    for (genvar i = 0; i < QUEUE_DEPTH - 1; i++) begin : g_order
        assign pair_ok[i] = !(r_count > OCC_W'(i + 1))
                            || (links[i].ent.pri >= links[i+1].ent.pri);
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word while an update is still running");

    a_insert_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> (r_left != '0))
        else $error("insert phase with nothing left to insert");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_PUSH) && (r_count != OCC_W'(QUEUE_DEPTH)))
        |=> (o_done && (o_occupancy == $past(r_count) + OCC_W'(1))))
        else $error("push did not add one entry");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (&pair_ok))
        else $error("queue out of priority order");

endmodule

`default_nettype wire
